// File: rtl/thpl_pkg.sv
// Shared types, constants and the calibration curve of the thermistor probe linearizer.
`default_nettype none

package thpl_pkg;

    localparam int SAMPLE_BITS  = 12;
    localparam int CURVE_POINTS = 19;
    localparam int IDX_W        = $clog2(CURVE_POINTS);
    localparam int DEG_W        = 8;
    localparam int RISE_W       = 8;
    localparam int PROD_W       = SAMPLE_BITS + RISE_W;
    localparam int CNT_W        = $clog2(PROD_W);
    localparam int TEMP_W       = 16;
    localparam int STATUS_W     = 3;
    localparam int EVENT_W      = 2;
    localparam int S_TDATA_W    = 16;
    localparam int M_TDATA_W    = 24;
    localparam int STATE_W      = TEMP_W + 1;

    typedef logic [SAMPLE_BITS-1:0] level_t;
    typedef logic signed [DEG_W-1:0] deg_t;
    typedef logic [IDX_W-1:0] idx_t;

    localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
    localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;

    localparam logic [STATUS_W-1:0] STATUS_VALID   = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_BELOW   = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE   = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOPROBE = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_HELD    = 3'd4;

    localparam logic [EVENT_W-1:0] EVENT_NONE       = 2'd0;
    localparam logic [EVENT_W-1:0] EVENT_CONNECT    = 2'd1;
    localparam logic [EVENT_W-1:0] EVENT_DISCONNECT = 2'd2;

    function automatic level_t cal_level(input idx_t idx);
        level_t lv;
        unique case (idx)
            5'd0:    lv = 12'd3790;
            5'd1:    lv = 12'd3046;
            5'd2:    lv = 12'd2226;
            5'd3:    lv = 12'd2120;
            5'd4:    lv = 12'd2016;
            5'd5:    lv = 12'd1724;
            5'd6:    lv = 12'd1664;
            5'd7:    lv = 12'd1407;
            5'd8:    lv = 12'd1104;
            5'd9:    lv = 12'd994;
            5'd10:   lv = 12'd812;
            5'd11:   lv = 12'd782;
            5'd12:   lv = 12'd584;
            5'd13:   lv = 12'd535;
            5'd14:   lv = 12'd474;
            5'd15:   lv = 12'd394;
            5'd16:   lv = 12'd370;
            5'd17:   lv = 12'd334;
            5'd18:   lv = 12'd321;
            default: lv = 12'd0;
        endcase
        return lv;
    endfunction

    function automatic deg_t cal_deg(input idx_t idx);
        deg_t dg;
        unique case (idx)
            5'd0:    dg = -8'sd20;
            5'd1:    dg = 8'sd4;
            5'd2:    dg = 8'sd22;
            5'd3:    dg = 8'sd24;
            5'd4:    dg = 8'sd26;
            5'd5:    dg = 8'sd32;
            5'd6:    dg = 8'sd34;
            5'd7:    dg = 8'sd40;
            5'd8:    dg = 8'sd49;
            5'd9:    dg = 8'sd52;
            5'd10:   dg = 8'sd58;
            5'd11:   dg = 8'sd59;
            5'd12:   dg = 8'sd69;
            5'd13:   dg = 8'sd71;
            5'd14:   dg = 8'sd75;
            5'd15:   dg = 8'sd81;
            5'd16:   dg = 8'sd83;
            5'd17:   dg = 8'sd86;
            5'd18:   dg = 8'sd88;
            default: dg = 8'sd0;
        endcase
        return dg;
    endfunction

endpackage

`default_nettype wire

// File: rtl/thpl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module thpl_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1
) (
    input  wire logic                                  aclk,
    input  wire logic                                  we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                      wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: rtl/thermistor_probe_linearizer.sv
// Top level of the thermistor probe linearizer: sequencer, curve search and serial divider.
//
// One input word per measurement tick arrives on the s_ channel; one result word per input
// word leaves on the m_ channel. The jack level of the previous tick and the held temperature
// live in a one-entry state RAM that is read at the start of each word and written back at
// its end. A valid flag, cleared by reset, makes the unwritten RAM read as jack low and the
// most negative temperature, so no clearing pass is needed.
// A word that needs no interpolation (probe absent, read failed, sample off the curve) goes
// from ST_EVAL straight to ST_DONE. Otherwise the search steps through the curve segments
// one per cycle; a sample exactly on the last curve point ends the search without a divide,
// and any other sample passes through ST_MUL into ST_DIV, the restoring divider producing
// one quotient bit per cycle. One word is worked on at a time; s_tready rises in the cycle
// the result is loaded, so a new word is accepted only after the previous one is finished.
// The result register parts the two channels: a new word may be accepted while the previous
// result waits, and the sequencer holds a finished result until the m_ side takes the old one.
// aresetn is synchronous and active low; it empties the result register and returns the
// sequencer to idle.
`default_nettype none

module thermistor_probe_linearizer (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // Fields from bit 0: jack_level[0], raw_sample[12:1], read_ok[13], zero fill[15:14].
    input  wire logic [thpl_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // Fields from bit 0: connected[0], temperature[16:1], status[19:17],
    // jack_event[21:20], zero fill[23:22].
    output logic      [thpl_pkg::M_TDATA_W-1:0]  m_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_EVAL   = 3'd2;
    localparam logic [2:0] ST_SEARCH = 3'd3;
    localparam logic [2:0] ST_MUL    = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    localparam int SB = thpl_pkg::SAMPLE_BITS;
    localparam int TW = thpl_pkg::TEMP_W;
    localparam int PW = thpl_pkg::PROD_W;
    localparam thpl_pkg::idx_t LAST_IDX = thpl_pkg::IDX_W'(thpl_pkg::CURVE_POINTS - 1);
    localparam thpl_pkg::idx_t STOP_IDX = thpl_pkg::IDX_W'(thpl_pkg::CURVE_POINTS - 2);

    logic [2:0]                         state_reg, state_next;
    logic                               jack_reg, jack_next;
    logic [SB-1:0]                      sample_reg, sample_next;
    logic                               ok_reg, ok_next;
    logic                               conn_reg, conn_next;
    logic [thpl_pkg::EVENT_W-1:0]       event_reg, event_next;
    logic signed [TW-1:0]               temp_reg, temp_next;
    logic [thpl_pkg::STATUS_W-1:0]      status_reg, status_next;
    thpl_pkg::idx_t                     idx_reg, idx_next;
    logic [SB-1:0]                      into_reg, into_next;
    logic [thpl_pkg::RISE_W-1:0]        rise_reg, rise_next;
    logic [SB-1:0]                      span_reg, span_next;
    logic signed [TW-1:0]               base_reg, base_next;
    logic [PW-1:0]                      quot_reg, quot_next;
    logic [SB-1:0]                      rem_reg, rem_next;
    logic [thpl_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic                               stv_reg, stv_next;
    logic                               m_tvalid_reg, m_tvalid_next;
    logic [thpl_pkg::M_TDATA_W-1:0]     m_tdata_reg, m_tdata_next;

    logic                               ram_we;
    logic [thpl_pkg::STATE_W-1:0]       ram_wdata;
    logic [thpl_pkg::STATE_W-1:0]       ram_rdata;

    logic                               prev_jack;
    logic signed [TW-1:0]               held_temp;
    thpl_pkg::level_t                   lvl_hi, lvl_lo;
    thpl_pkg::deg_t                     deg_hi, deg_lo;
    logic signed [thpl_pkg::DEG_W:0]    deg_diff;
    logic [thpl_pkg::DEG_W:0]           deg_abs;
    logic [SB:0]                        rem_shift;
    logic                               qbit;
    logic [PW-1:0]                      quot_shift;

    thpl_ram #(
        .WIDTH(thpl_pkg::STATE_W),
        .DEPTH(1)
    ) u_state_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (1'b0),
        .wdata (ram_wdata),
        .raddr (1'b0),
        .rdata (ram_rdata)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign ram_we    = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);
    assign ram_wdata = {jack_reg, temp_reg};

    always_comb begin
        prev_jack  = stv_reg ? ram_rdata[TW] : 1'b0;
        held_temp  = stv_reg ? $signed(ram_rdata[TW-1:0]) : thpl_pkg::TEMP_MIN;
        lvl_hi     = thpl_pkg::cal_level(idx_reg);
        lvl_lo     = thpl_pkg::cal_level(idx_reg + thpl_pkg::IDX_W'(1));
        deg_hi     = thpl_pkg::cal_deg(idx_reg);
        deg_lo     = thpl_pkg::cal_deg(idx_reg + thpl_pkg::IDX_W'(1));
        deg_diff   = $signed({deg_lo[thpl_pkg::DEG_W-1], deg_lo})
                   - $signed({deg_hi[thpl_pkg::DEG_W-1], deg_hi});
        deg_abs    = deg_diff[thpl_pkg::DEG_W] ? (~deg_diff + 1'b1) : deg_diff;
        rem_shift  = {rem_reg, quot_reg[PW-1]};
        qbit       = (rem_shift >= {1'b0, span_reg});
        quot_shift = {quot_reg[PW-2:0], qbit};

        state_next    = state_reg;
        jack_next     = jack_reg;
        sample_next   = sample_reg;
        ok_next       = ok_reg;
        conn_next     = conn_reg;
        event_next    = event_reg;
        temp_next     = temp_reg;
        status_next   = status_reg;
        idx_next      = idx_reg;
        into_next     = into_reg;
        rise_next     = rise_reg;
        span_next     = span_reg;
        base_next     = base_reg;
        quot_next     = quot_reg;
        rem_next      = rem_reg;
        cnt_next      = cnt_reg;
        stv_next      = stv_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    jack_next   = s_tdata[0];
                    sample_next = s_tdata[SB:1];
                    ok_next     = s_tdata[SB+1];
                    state_next  = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                conn_next = jack_reg && prev_jack;
                if (jack_reg && !prev_jack) begin
                    event_next = thpl_pkg::EVENT_CONNECT;
                end else if (!jack_reg && prev_jack) begin
                    event_next = thpl_pkg::EVENT_DISCONNECT;
                end else begin
                    event_next = thpl_pkg::EVENT_NONE;
                end
                state_next = ST_DONE;
                idx_next   = '0;
                if (!(jack_reg && prev_jack)) begin
                    temp_next   = thpl_pkg::TEMP_MIN;
                    status_next = thpl_pkg::STATUS_NOPROBE;
                end else if (!ok_reg) begin
                    temp_next   = held_temp;
                    status_next = thpl_pkg::STATUS_HELD;
                end else if (sample_reg > thpl_pkg::cal_level('0)) begin
                    temp_next   = thpl_pkg::TEMP_MIN;
                    status_next = thpl_pkg::STATUS_BELOW;
                end else if (sample_reg < thpl_pkg::cal_level(LAST_IDX)) begin
                    temp_next   = thpl_pkg::TEMP_MAX;
                    status_next = thpl_pkg::STATUS_ABOVE;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                if ((sample_reg <= lvl_hi) && (sample_reg > lvl_lo)) begin
                    into_next  = lvl_hi - sample_reg;
                    span_next  = lvl_hi - lvl_lo;
                    rise_next  = deg_abs[thpl_pkg::RISE_W-1:0];
                    base_next  = TW'(deg_hi);
                    state_next = ST_MUL;
                end else if (idx_reg == STOP_IDX) begin
                    state_next = ST_DONE;
                    if (sample_reg == lvl_lo) begin
                        temp_next   = TW'(deg_lo);
                        status_next = thpl_pkg::STATUS_VALID;
                    end else begin
                        temp_next   = thpl_pkg::TEMP_MIN;
                        status_next = thpl_pkg::STATUS_BELOW;
                    end
                end else begin
                    idx_next = idx_reg + thpl_pkg::IDX_W'(1);
                end
            end
            ST_MUL: begin
                quot_next  = PW'(into_reg * rise_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                rem_next  = qbit ? SB'(rem_shift - {1'b0, span_reg}) : rem_shift[SB-1:0];
                quot_next = quot_shift;
                cnt_next  = cnt_reg + thpl_pkg::CNT_W'(1);
                if (cnt_reg == thpl_pkg::CNT_W'(PW - 1)) begin
                    temp_next   = base_reg + $signed(quot_shift[TW-1:0]);
                    status_next = thpl_pkg::STATUS_VALID;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, event_reg, status_reg, temp_reg, conn_reg};
                    stv_next      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            stv_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            stv_reg      <= stv_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        jack_reg    <= jack_next;
        sample_reg  <= sample_next;
        ok_reg      <= ok_next;
        conn_reg    <= conn_next;
        event_reg   <= event_next;
        temp_reg    <= temp_next;
        status_reg  <= status_next;
        idx_reg     <= idx_next;
        into_reg    <= into_next;
        rise_reg    <= rise_next;
        span_reg    <= span_next;
        base_reg    <= base_next;
        quot_reg    <= quot_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule

`default_nettype wire

// File: rtl/thpl_checker.sv
// Port-level checker for the thermistor probe linearizer and its bind statement.
`default_nettype none

module thpl_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [thpl_pkg::M_TDATA_W-1:0]  m_tdata
);

    // A stalled result word keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // The probe is reported absent exactly when the connected flag is low.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[19:17] != thpl_pkg::STATUS_NOPROBE)))
        else $error("connected flag disagrees with status");

    // Off-curve and absent-probe results carry the saturated codes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[19:17] == thpl_pkg::STATUS_ABOVE)
        |-> m_tdata[16:1] == 16'h7FFF)
        else $error("too hot result without the most positive code");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && ((m_tdata[19:17] == thpl_pkg::STATUS_BELOW) ||
                     (m_tdata[19:17] == thpl_pkg::STATUS_NOPROBE))
        |-> m_tdata[16:1] == 16'h8000)
        else $error("too cold or absent result without the most negative code");

    // Only defined status and event codes leave the block.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[19:17] <= thpl_pkg::STATUS_HELD) &&
                     (m_tdata[21:20] != 2'd3))
        else $error("undefined status or event code");

endmodule

bind thermistor_probe_linearizer thpl_checker u_thpl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: test/thpl_checker.sv
// Checker for the thermistor probe linearizer: predicts each result word and compares it.
module thpl_scoreboard (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [thpl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [thpl_pkg::M_TDATA_W-1:0] m_tdata,
    output int                             mismatches,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic                                 connected;
        logic signed [thpl_pkg::TEMP_W-1:0]   temperature;
        logic [thpl_pkg::STATUS_W-1:0]        status;
        logic [thpl_pkg::EVENT_W-1:0]         jack_event;
    } reading_t;

    int cal_lv [0:thpl_pkg::CURVE_POINTS-1] = '{3790, 3046, 2226, 2120, 2016, 1724, 1664,
                                                1407, 1104, 994, 812, 782, 584, 535, 474,
                                                394, 370, 334, 321};
    int cal_dg [0:thpl_pkg::CURVE_POINTS-1] = '{-20, 4, 22, 24, 26, 32, 34, 40, 49, 52, 58,
                                                59, 69, 71, 75, 81, 83, 86, 88};

    reading_t                           expected_readings [$];
    logic                               last_jack;
    logic signed [thpl_pkg::TEMP_W-1:0] held_temp;
    int                                 result_words;

    function automatic int curve_temperature(input int s,
                                             output logic [thpl_pkg::STATUS_W-1:0] st);
        int span;
        int rise;
        int into;
        st = thpl_pkg::STATUS_VALID;
        if (s > cal_lv[0]) begin
            st = thpl_pkg::STATUS_BELOW;
            return int'(thpl_pkg::TEMP_MIN);
        end
        if (s < cal_lv[thpl_pkg::CURVE_POINTS-1]) begin
            st = thpl_pkg::STATUS_ABOVE;
            return int'(thpl_pkg::TEMP_MAX);
        end
        for (int k = 0; k + 1 < thpl_pkg::CURVE_POINTS; k++) begin
            if (s <= cal_lv[k] && s > cal_lv[k+1]) begin
                span = cal_lv[k] - cal_lv[k+1];
                rise = (cal_dg[k+1] >= cal_dg[k]) ? cal_dg[k+1] - cal_dg[k]
                                                  : cal_dg[k] - cal_dg[k+1];
                into = cal_lv[k] - s;
                return (into * rise) / span + cal_dg[k];
            end
        end
        if (s == cal_lv[thpl_pkg::CURVE_POINTS-1]) begin
            return cal_dg[thpl_pkg::CURVE_POINTS-1];
        end
        st = thpl_pkg::STATUS_BELOW;
        return int'(thpl_pkg::TEMP_MIN);
    endfunction

    function automatic reading_t convert_tick(input logic jack, input thpl_pkg::level_t raw,
                                              input logic ok);
        reading_t                      r;
        logic [thpl_pkg::STATUS_W-1:0] st;
        int                            t;
        r.connected = jack && last_jack;
        if (jack && !last_jack) begin
            r.jack_event = thpl_pkg::EVENT_CONNECT;
        end else if (!jack && last_jack) begin
            r.jack_event = thpl_pkg::EVENT_DISCONNECT;
        end else begin
            r.jack_event = thpl_pkg::EVENT_NONE;
        end
        last_jack = jack;
        if (r.connected) begin
            if (ok) begin
                t = curve_temperature(int'(raw), st);
                held_temp = thpl_pkg::TEMP_W'(t);
                r.temperature = thpl_pkg::TEMP_W'(t);
                r.status = st;
            end else begin
                r.temperature = held_temp;
                r.status = thpl_pkg::STATUS_HELD;
            end
        end else begin
            held_temp = thpl_pkg::TEMP_MIN;
            r.temperature = thpl_pkg::TEMP_MIN;
            r.status = thpl_pkg::STATUS_NOPROBE;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        reading_t got;
        reading_t want;
        if (!aresetn) begin
            expected_readings.delete();
            last_jack = 1'b0;
            held_temp = thpl_pkg::TEMP_MIN;
            mismatches = 0;
            result_words = 0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_readings.push_back(convert_tick(s_tdata[0], s_tdata[12:1],
                                                         s_tdata[13]));
            end
            if (m_tvalid && m_tready) begin
                got.connected   = m_tdata[0];
                got.temperature = m_tdata[16:1];
                got.status      = m_tdata[19:17];
                got.jack_event  = m_tdata[21:20];
                if (expected_readings.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("result word %0d arrived with none expected: %h",
                                 result_words, m_tdata);
                    end
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.connected !== want.connected
                            || got.temperature !== want.temperature
                            || got.status !== want.status
                            || got.jack_event !== want.jack_event) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $write("result word %0d: expected conn=%0d temp=%0d ",
                                   result_words, want.connected, want.temperature);
                            $write("status=%0d event=%0d, ", want.status, want.jack_event);
                            $display("got conn=%0d temp=%0d status=%0d event=%0d",
                                     got.connected, got.temperature, got.status,
                                     got.jack_event);
                        end
                        mismatches++;
                    end
                end
                result_words++;
            end
        end
        pending = expected_readings.size();
    end

endmodule

// File: test/tb_thermistor_probe_linearizer.sv
// Testbench top for the thermistor probe linearizer: clock, reset, stimulus and verdict.
module tb_thermistor_probe_linearizer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_WORDS   = 450;
    localparam int IDLE_LIMIT     = 1000;
    localparam int DRAIN_CYCLES   = 60;

    logic                           aclk;
    logic                           aresetn;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [thpl_pkg::S_TDATA_W-1:0] s_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [thpl_pkg::M_TDATA_W-1:0] m_tdata;
    int                             mismatches;
    int                             pending;
    int                             idle_cycles = 0;
    int                             tx_idle_max;
    int                             rx_idle_max;

    thermistor_probe_linearizer uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    thpl_scoreboard u_scoreboard (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_word(input logic jack, input thpl_pkg::level_t raw, input logic ok);
        int gap;
        gap = $urandom_range(0, tx_idle_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, ok, raw, jack};
        do @(posedge aclk); while (!s_tready);
    endtask

    function automatic thpl_pkg::level_t pick_sample();
        int pick;
        int idx;
        pick = $urandom_range(0, 9);
        if (pick <= 5) begin
            return thpl_pkg::level_t'($urandom_range(321, 3790));
        end else if (pick <= 7) begin
            idx = $urandom_range(0, thpl_pkg::CURVE_POINTS - 1);
            return thpl_pkg::level_t'(int'(thpl_pkg::cal_level(thpl_pkg::idx_t'(idx)))
                                      + $urandom_range(0, 2) - 1);
        end
        return thpl_pkg::level_t'($urandom_range(0, 4095));
    endfunction

    initial begin
        int stall;
        m_tready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = $urandom_range(0, rx_idle_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        logic jack_now;
        tx_idle_max = 4;
        rx_idle_max = 4;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_word(1'b0, 12'd4095, 1'b1);
        send_word(1'b1, 12'd0,    1'b0);
        send_word(1'b1, 12'd0,    1'b0);
        send_word(1'b1, 12'd3790, 1'b1);
        send_word(1'b1, 12'd3791, 1'b1);
        send_word(1'b1, 12'd4095, 1'b1);
        send_word(1'b1, 12'd321,  1'b1);
        send_word(1'b1, 12'd320,  1'b1);
        send_word(1'b1, 12'd0,    1'b1);
        send_word(1'b1, 12'd322,  1'b1);
        send_word(1'b1, 12'd2000, 1'b0);
        send_word(1'b1, 12'd3046, 1'b1);
        send_word(1'b1, 12'd3045, 1'b1);
        send_word(1'b1, 12'd1000, 1'b1);
        send_word(1'b1, 12'd2226, 1'b1);
        send_word(1'b1, 12'd4095, 1'b0);
        send_word(1'b0, 12'd1234, 1'b1);
        send_word(1'b0, 12'd0,    1'b0);
        send_word(1'b1, 12'd4095, 1'b0);
        send_word(1'b1, 12'd2120, 1'b1);
        send_word(1'b1, 12'd1,    1'b1);
        send_word(1'b1, 12'd2730, 1'b1);
        send_word(1'b1, 12'd1365, 1'b0);

        jack_now = 1'b1;
        for (int i = 0; i < RANDOM_WORDS; i++) begin
            if (i == RANDOM_WORDS / 3) begin
                tx_idle_max = 0;
                rx_idle_max = 0;
            end else if (i == 2 * RANDOM_WORDS / 3) begin
                tx_idle_max = 1;
                rx_idle_max = 4;
            end
            if (jack_now ? ($urandom_range(0, 11) == 0) : ($urandom_range(0, 2) == 0)) begin
                jack_now = !jack_now;
            end
            send_word(jack_now, pick_sample(), $urandom_range(0, 7) != 0);
        end
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
